>>> hw/rtl/mslsg_pkg.sv
`default_nettype none

package mslsg_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // Mask is eight bits wide, so a tick never scans past slot seven.
    localparam int SCAN_N  = (SLOTS < 8) ? SLOTS : 8;
    localparam int CNT_W   = 4;

    localparam logic [7:0] NO_MIRROR = 8'd255;

    localparam logic KIND_PREPARE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic signed [15:0] pos_now;
        logic signed [15:0] pos_end;
        logic [7:0]         val_now;
        logic [7:0]         val_end;
        logic signed [16:0] delta_pos;
        logic [7:0]         delta_val;
        logic signed [17:0] err;
        logic               dir;
        logic               steep;
        logic [7:0]         mirror;
    } slot_st_t;

    localparam slot_st_t SLOT_RESET = '{
        pos_now:   16'sd0,
        pos_end:   16'sd0,
        val_now:   8'd0,
        val_end:   8'd0,
        delta_pos: 17'sd0,
        delta_val: 8'd0,
        err:       18'sd0,
        dir:       1'b0,
        steep:     1'b0,
        mirror:    NO_MIRROR
    };

    typedef struct packed {
        logic               wr;
        logic               clr;
        logic [SLOT_AW-1:0] addr;
        slot_st_t           data;
    } ram_wr_t;

    typedef struct packed {
        logic       push;
        logic       close;
        logic [2:0] slot;
        logic [6:0] value;
    } res_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_LOOP,
        ST_EMIT,
        ST_CLOSE
    } ctrl_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mslsg_slot_ram.sv
`default_nettype none

module mslsg_slot_ram
    import mslsg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ram_wr_t            wr,
    input  wire logic               rd_en,
    input  wire logic [SLOT_AW-1:0] rd_addr,
    output slot_st_t                rd_data
);

    slot_st_t           mem [SLOTS];
    slot_st_t           rd_data_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]   valid_next;
    logic               rd_valid_reg;
    logic               rd_valid_next;

    // Store only; an entry that is not valid reads as the reset state.
    always_ff @(posedge clk)
    begin
        if (wr.wr && !wr.clr)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (wr.wr)
        begin
            valid_next[wr.addr] = !wr.clr;
        end
        if (rd_en)
        begin
            rd_valid_next = valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : SLOT_RESET;

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.wr && rd_en) |-> (wr.addr != rd_addr))
        else $error("slot ram read and write hit the same entry");

endmodule

`default_nettype wire

>>> hw/rtl/mslsg_out_buf.sv
`default_nettype none

module mslsg_out_buf
    import mslsg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire res_req_t req,
    output logic          req_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [2:0]    slot_out,
    output logic [6:0]    value,
    output logic          last
);

    logic       pend_valid_reg, pend_valid_next;
    logic [2:0] pend_slot_reg, pend_slot_next;
    logic [6:0] pend_value_reg, pend_value_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] slot_out_reg, slot_out_next;
    logic [6:0] value_reg, value_next;
    logic       last_reg, last_next;
    logic       out_free;
    logic       fire_push;
    logic       fire_close;
    logic       load_out;

    // Hold the newest word back until the next one or the end of the tick
    // tells whether it is the last.
    assign out_free   = !out_valid_reg || out_ready;
    assign req_ready  = !pend_valid_reg || out_free;
    assign fire_push  = req.push && req_ready;
    assign fire_close = req.close && req_ready;
    assign load_out   = pend_valid_reg && (fire_push || fire_close);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg;
        slot_out_next   = slot_out_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            slot_out_next  = pend_slot_reg;
            value_next     = pend_value_reg;
            last_next      = fire_close;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire_push)
        begin
            pend_valid_next = 1'b1;
            pend_slot_next  = req.slot;
            pend_value_next = req.value;
        end
        else if (fire_close)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg  <= pend_slot_next;
        pend_value_reg <= pend_value_next;
        slot_out_reg   <= slot_out_next;
        value_reg      <= value_next;
        last_reg       <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    a_push_close_apart: assert property (@(posedge clk) disable iff (!rst_n)
        req.push |-> !req.close)
        else $error("push and close requested together");

    a_close_drains: assert property (@(posedge clk) disable iff (!rst_n)
        fire_close |=> !pend_valid_reg)
        else $error("held word survived the end of a tick");

endmodule

`default_nettype wire

>>> hw/rtl/mslsg_ctrl.sv
`default_nettype none

module mslsg_ctrl
    import mslsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [2:0]  slot,
    input  wire logic [13:0] start_pos,
    input  wire logic [13:0] end_pos,
    input  wire logic [6:0]  start_value,
    input  wire logic [6:0]  end_value,
    input  wire logic [7:0]  enable_mask,
    output ram_wr_t          wr,
    output logic             rd_en,
    output logic [SLOT_AW-1:0] rd_addr,
    input  wire slot_st_t    rd_data,
    output res_req_t         req,
    input  wire logic        req_ready
);

    ctrl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         mask_reg, mask_next;
    slot_st_t           work_reg, work_next;
    logic signed [15:0] old_pos_reg, old_pos_next;
    logic [7:0]         val_orig_reg, val_orig_next;
    logic [6:0]         res_val_reg, res_val_next;
    logic               res_clr_reg, res_clr_next;

    logic               accept;
    logic               scan_done;
    logic               slot_on;
    logic               slot_ok;

    // prepare
    logic signed [17:0] pp0, pp1, pv0, pv1, dpr, dvr, adp, adv;
    logic signed [17:0] sp0, sp1, sv0, sv1, dp, dv, dpm, dvm, dp2, dv2, ierr;
    logic               steep, swap, idir;
    slot_st_t           prep;

    // steep step on the word just read
    logic               st_gt;
    logic [7:0]         st_val;
    logic signed [17:0] st_err;
    logic signed [15:0] st_pos;
    logic               st_done;

    // one iteration of the shallow walk
    logic               lp_gt;
    logic signed [15:0] lp_pos;
    logic signed [17:0] lp_err;
    logic [7:0]         lp_val;
    logic               lp_clear;
    logic               lp_moved;
    logic [7:0]         mir_val;

    assign accept    = in_valid && in_ready;
    assign scan_done = (cnt_reg == CNT_W'(SCAN_N));
    assign slot_on   = mask_reg[cnt_reg[2:0]];
    assign slot_ok   = (int'(slot) < SLOTS);

    always_comb
    begin
        pp0 = $signed({4'b0, start_pos});
        pp1 = $signed({4'b0, end_pos});
        pv0 = $signed({11'b0, start_value});
        pv1 = $signed({11'b0, end_value});
        dpr = pp1 - pp0;
        dvr = pv1 - pv0;
        adp = (dpr < 0) ? -dpr : dpr;
        adv = (dvr < 0) ? -dvr : dvr;
        steep = (adv < adp);
        swap  = !steep && (pv0 > pv1);
        sp0 = swap ? pp1 : pp0;
        sp1 = swap ? pp0 : pp1;
        sv0 = swap ? pv1 : pv0;
        sv1 = swap ? pv0 : pv1;
        dp  = sp1 - sp0;
        dv  = sv1 - sv0;
        dpm = (dp < 0) ? -dp : dp;
        dvm = (dv < 0) ? -dv : dv;
        if (steep)
        begin
            idir = (dv < 0);
            dv2  = dvm + dvm;
            dp2  = dp + dp;
            ierr = dv2 - dp;
        end
        else
        begin
            idir = (dp < 0);
            dp2  = dpm + dpm;
            dv2  = dv + dv;
            ierr = dp2 - dv;
        end
        prep.pos_now   = 16'(sp0);
        prep.pos_end   = 16'(sp1);
        prep.val_now   = 8'(sv0);
        prep.val_end   = 8'(sv1);
        prep.delta_pos = 17'(dp2);
        prep.delta_val = 8'(dv2);
        prep.err       = ierr;
        prep.dir       = idir;
        prep.steep     = steep;
        prep.mirror    = swap ? 8'(sv0) : NO_MIRROR;
    end

    always_comb
    begin
        st_gt   = (rd_data.err > 18'sd0);
        st_val  = rd_data.val_now;
        st_err  = rd_data.err;
        if (st_gt)
        begin
            st_val = rd_data.dir ? (rd_data.val_now - 8'd1) : (rd_data.val_now + 8'd1);
            st_err = rd_data.err - 18'(rd_data.delta_pos);
        end
        st_err  = st_err + $signed({10'b0, rd_data.delta_val});
        st_pos  = rd_data.pos_now + 16'sd1;
        st_done = (st_pos >= rd_data.pos_end);
    end

    always_comb
    begin
        lp_gt  = (work_reg.err > 18'sd0);
        lp_pos = work_reg.pos_now;
        lp_err = work_reg.err;
        if (lp_gt)
        begin
            lp_pos = work_reg.dir ? (work_reg.pos_now - 16'sd1) : (work_reg.pos_now + 16'sd1);
            lp_err = work_reg.err - $signed({10'b0, work_reg.delta_val});
        end
        lp_err   = lp_err + 18'(work_reg.delta_pos);
        lp_val   = work_reg.val_now + 8'd1;
        lp_clear = (lp_val >= work_reg.val_end);
        lp_moved = (lp_pos != old_pos_reg);
        mir_val  = work_reg.val_end - val_orig_reg + work_reg.mirror;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_TICK))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (scan_done)
                begin
                    state_next = ST_CLOSE;
                end
                else if (slot_on)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (rd_data.delta_val == 8'd0)
                begin
                    state_next = ST_READ;
                end
                else if (rd_data.steep)
                begin
                    state_next = st_done ? ST_CLOSE : ST_EMIT;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (lp_clear || lp_moved)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (req_ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_CLOSE:
            begin
                if (req_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cnt_reg[SLOT_AW-1:0];
        wr.wr     = 1'b0;
        wr.clr    = 1'b0;
        wr.addr   = cnt_reg[SLOT_AW-1:0];
        wr.data   = work_reg;
        req.push  = 1'b0;
        req.close = 1'b0;
        req.slot  = 3'(cnt_reg);
        req.value = res_val_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                wr.addr  = SLOT_AW'(slot);
                wr.data  = prep;
                wr.wr    = accept && (kind == KIND_PREPARE) && slot_ok;
            end
            ST_READ:
            begin
                rd_en = !scan_done && slot_on;
            end
            ST_EVAL:
            begin
                // Finished steep slot: drop it and end the scan.
                wr.wr  = (rd_data.delta_val != 8'd0) && rd_data.steep && st_done;
                wr.clr = 1'b1;
            end
            ST_EMIT:
            begin
                req.push = 1'b1;
                wr.wr    = req_ready;
                wr.clr   = res_clr_reg;
            end
            ST_CLOSE:
            begin
                req.close = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        work_next     = work_reg;
        old_pos_next  = old_pos_reg;
        val_orig_next = val_orig_reg;
        res_val_next  = res_val_reg;
        res_clr_next  = res_clr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_TICK))
                begin
                    mask_next = enable_mask;
                    cnt_next  = '0;
                end
            end
            ST_READ:
            begin
                if (!scan_done && !slot_on)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EVAL:
            begin
                work_next     = rd_data;
                old_pos_next  = rd_data.pos_now;
                val_orig_next = rd_data.val_now;
                res_val_next  = rd_data.val_now[6:0];
                res_clr_next  = 1'b0;
                if (rd_data.delta_val == 8'd0)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (rd_data.steep)
                begin
                    work_next.val_now = st_val;
                    work_next.err     = st_err;
                    work_next.pos_now = st_pos;
                end
            end
            ST_LOOP:
            begin
                work_next.pos_now = lp_pos;
                work_next.err     = lp_err;
                work_next.val_now = lp_val;
                if (lp_clear)
                begin
                    res_clr_next = 1'b1;
                    res_val_next = val_orig_reg[6:0];
                end
                else if (lp_moved)
                begin
                    res_clr_next = 1'b0;
                    res_val_next = (work_reg.mirror != NO_MIRROR) ? mir_val[6:0]
                                                                  : val_orig_reg[6:0];
                end
            end
            ST_EMIT:
            begin
                if (req_ready)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        work_reg     <= work_next;
        old_pos_reg  <= old_pos_next;
        val_orig_reg <= val_orig_next;
        res_val_reg  <= res_val_next;
        res_clr_reg  <= res_clr_next;
    end

    a_loop_shallow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> (!work_reg.steep && (work_reg.delta_val != 8'd0)))
        else $error("walk loop entered for a steep or idle slot");

endmodule

`default_nettype wire

>>> hw/rtl/multi_slot_line_slide_generator.sv
// Multi-slot line slide generator: a shared line stepper, state per slot in
// a small synchronous slot memory that is read, stepped and written back.
// Input channel (in_valid/in_ready): a word with kind = prepare loads one
// slot from start/end position and value; it gives no output, and the block
// is ready again on the next cycle. A word with kind = tick scans slots 0
// upward: each slot enabled in enable_mask and still active gives one
// output word (slot_out, value), in slot order, with last set on the final
// word of that tick. A steep slot that reaches its end is dropped without
// output and ends the scan.
// Tick sequence: a masked-out slot is skipped; a steep slot is read,
// evaluated and emitted; a shallow slot is read and evaluated, then walks
// one value step per iteration until its position moves or its value
// reaches the end, and is emitted; a closing step ends the tick. The next
// word is taken once the tick is closed.
// Output channel (out_valid/out_ready): registered, with one held-back word
// to mark last. A stalled receiver holds the scan; no word is lost.
// Reset clears all slots to inactive at once through per-slot valid bits.
`default_nettype none

module multi_slot_line_slide_generator
    import mslsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [2:0]  slot,
    input  wire logic [13:0] start_pos,
    input  wire logic [13:0] end_pos,
    input  wire logic [6:0]  start_value,
    input  wire logic [6:0]  end_value,
    input  wire logic [7:0]  enable_mask,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       slot_out,
    output logic [6:0]       value,
    output logic             last
);

    ram_wr_t            wr;
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    slot_st_t           rd_data;
    res_req_t           req;
    logic               req_ready;

    // Sequencer: scan, step and write back one slot at a time.
    mslsg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .slot        (slot),
        .start_pos   (start_pos),
        .end_pos     (end_pos),
        .start_value (start_value),
        .end_value   (end_value),
        .enable_mask (enable_mask),
        .wr          (wr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .req         (req),
        .req_ready   (req_ready)
    );

    // Slot state store with a registered read.
    mslsg_slot_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register plus held word for the last flag.
    mslsg_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .slot_out  (slot_out),
        .value     (value),
        .last      (last)
    );

endmodule

`default_nettype wire
